### hw/rtl/bcr_pkg.sv
// ============================================================================
// bcr_pkg
// Shared types and constants for the braille cell bitmap renderer.
// ============================================================================
package bcr_pkg;

    localparam int CODE_W = 8;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_RENDER
    } state_t;

    localparam logic ADDR_WIDTH_REG  = 1'b0;
    localparam logic ADDR_HEIGHT_REG = 1'b1;

    // Used drawing area after rounding and capping.
    typedef struct packed {
        logic [8:0] w_used;
        logic [7:0] h_used;
        logic [7:0] cells;
        logic [5:0] bands;
    } geom_t;

    // Dot position inside a cell word from the low row and column bits.
    function automatic logic [2:0] dot_pos(input logic [1:0] row_lo, input logic col_lo);
        logic [2:0] pos;
        pos = 3'd0;
        case ({col_lo, row_lo})
            3'b011:  pos = 3'd0;
            3'b010:  pos = 3'd1;
            3'b001:  pos = 3'd2;
            3'b000:  pos = 3'd6;
            3'b111:  pos = 3'd3;
            3'b110:  pos = 3'd4;
            3'b101:  pos = 3'd5;
            3'b100:  pos = 3'd7;
            default: pos = 3'd0;
        endcase
        return pos;
    endfunction

endpackage

### hw/rtl/bcr_if.sv
// ============================================================================
// bcr_if
// Command and result channels of the braille cell bitmap renderer.
// ============================================================================
interface bcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [5:0] row;
    logic [6:0] column;
    logic       pixel_value;
    logic [3:0] line_index;

    modport source (output valid, cmd, row, column, pixel_value, line_index, input ready);
    modport sink   (input valid, cmd, row, column, pixel_value, line_index, output ready);
endinterface

interface bcr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_code;
    logic       pixel_bit;
    logic       last;

    modport source (output valid, cell_code, pixel_bit, last, input ready);
    modport sink   (input valid, cell_code, pixel_bit, last, output ready);
endinterface

### hw/rtl/braille_cell_bitmap_renderer.sv
// ============================================================================
// braille_cell_bitmap_renderer
// One-bit pixel canvas rendered as 2x4 braille cells.
// ============================================================================
// Usage:
//   req carries one command per transaction: write a pixel, read a pixel or
//   render one text line. rsp returns one transaction per result; last marks
//   the final cell of a line and every read result.
//   The canvas is held as one 8-bit word per cell in a single-port-read,
//   single-port-write memory, so all work goes through that one memory.
//   Write: read, merge and write back; no result.
//   Read: a memory read, then the result register once it is free.
//   Render: fetch the first cell, then one cell per cycle while rsp does
//   not stall; a line outside the area gives no result.
//   req.ready is high only while the sequencer is idle.
//   After reset the memory is swept to zero, one word a cycle, over all
//   2**ADDR_W words (1024 with the default sizes); req.ready stays low
//   meanwhile while APB writes are taken as usual.
//   When rsp stalls, the finished result waits in the output register and
//   the sequencer holds its current cell until the register frees up.
//   Registers: width_in_use at 0x0, height_in_use at 0x4.
// ============================================================================
module braille_cell_bitmap_renderer #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    bcr_req_if.sink     req,
    bcr_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BANDS  = MAX_HEIGHT / 4;
    localparam int CELLS  = MAX_WIDTH / 2;
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ADDR_W = BAND_W + CELL_W;

    bcr_pkg::geom_t  geom;
    bcr_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]          clr_reg, clr_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [2:0]                 pos_reg, pos_next;
    logic                       val_reg, val_next;
    logic                       area_reg, area_next;
    logic [6:0]                 cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bcr_pkg::CODE_W-1:0] out_code_reg, out_code_next;
    logic                       out_bit_reg, out_bit_next;
    logic                       out_last_reg, out_last_next;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [bcr_pkg::CODE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [bcr_pkg::CODE_W-1:0] mem_rdata;

    logic                       accept;
    logic                       in_area;
    logic [5:0]                 band_calc;
    logic [ADDR_W-1:0]          req_addr;
    logic                       slot_free;
    logic                       load;
    logic                       cell_last;
    logic [bcr_pkg::CODE_W-1:0] merged;

    bcr_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    bcr_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == bcr_pkg::ST_IDLE);
    assign accept    = req.valid & req.ready;
    assign in_area   = ({2'b0, req.row} < geom.h_used) && ({2'b0, req.column} < geom.w_used);
    assign band_calc = geom.bands - 6'd1 - {2'b0, req.line_index};
    assign req_addr  = {BAND_W'(req.row[5:2]), CELL_W'(req.column[6:1])};
    assign slot_free = !out_valid_reg || rsp.ready;
    assign cell_last = (({1'b0, cnt_reg} + 8'd1) == geom.cells);

    always_comb
    begin
        merged          = mem_rdata;
        merged[pos_reg] = val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcr_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        area_reg     <= area_next;
        cnt_reg      <= cnt_next;
        out_code_reg <= out_code_next;
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        area_next      = area_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_code_next  = out_code_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = merged;
        mem_re         = 1'b0;
        mem_raddr      = req_addr;
        load           = 1'b0;

        case (state_reg)
            bcr_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = bcr_pkg::ST_IDLE;
                end
            end
            bcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = req_addr;
                    pos_next  = bcr_pkg::dot_pos(req.row[1:0], req.column[0]);
                    val_next  = req.pixel_value;
                    area_next = in_area;
                    cnt_next  = '0;
                    case (req.cmd)
                        bcr_pkg::CMD_WRITE:
                        begin
                            if (in_area)
                            begin
                                mem_re     = 1'b1;
                                state_next = bcr_pkg::ST_WRITE;
                            end
                        end
                        bcr_pkg::CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = bcr_pkg::ST_READ;
                        end
                        bcr_pkg::CMD_RENDER:
                        begin
                            if ({2'b0, req.line_index} < geom.bands)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = {BAND_W'(band_calc), CELL_W'(0)};
                                addr_next  = mem_raddr;
                                state_next = bcr_pkg::ST_RENDER;
                            end
                        end
                        default:
                        begin
                            state_next = bcr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bcr_pkg::ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = bcr_pkg::ST_IDLE;
            end
            bcr_pkg::ST_READ:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    out_code_next  = '0;
                    out_bit_next   = area_reg & mem_rdata[pos_reg];
                    out_last_next  = 1'b1;
                    state_next     = bcr_pkg::ST_IDLE;
                end
            end
            bcr_pkg::ST_RENDER:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    out_code_next  = mem_rdata;
                    out_bit_next   = 1'b0;
                    out_last_next  = cell_last;
                    if (cell_last)
                    begin
                        state_next = bcr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 7'd1;
                        mem_re    = 1'b1;
                        mem_raddr = {addr_reg[ADDR_W-1:CELL_W], CELL_W'(cnt_reg + 7'd1)};
                    end
                end
            end
            default:
            begin
                state_next = bcr_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.cell_code = out_code_reg;
    assign rsp.pixel_bit = out_bit_reg;
    assign rsp.last      = out_last_reg;

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcr_pkg::ST_CLEAR) |-> !rsp.valid)
        else $error("result during memory clear");

    a_write_commits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == bcr_pkg::CMD_WRITE && in_area)
        |=> (state_reg == bcr_pkg::ST_WRITE && mem_we))
        else $error("pixel write not committed");

    a_last_cell_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcr_pkg::ST_RENDER && load && out_last_next)
        |=> (state_reg == bcr_pkg::ST_IDLE && rsp.valid && rsp.last))
        else $error("render did not end on last cell");

    a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.pixel_bit) |-> (rsp.cell_code == '0 && rsp.last))
        else $error("malformed read result");
`endif

endmodule

### hw/rtl/bcr_store.sv
// ============================================================================
// bcr_store
// Cell word memory: one 8-bit word per 2x4 cell, registered read.
// ============================================================================
module bcr_store #(
    parameter int ADDR_W = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [bcr_pkg::CODE_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [bcr_pkg::CODE_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [bcr_pkg::CODE_W-1:0] mem [DEPTH];
    logic [bcr_pkg::CODE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bcr_cfg.sv
// ============================================================================
// bcr_cfg
// APB register file for the used area and derivation of its geometry.
// ============================================================================
module bcr_cfg #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bcr_pkg::geom_t geom
);

    localparam int CAP_W = (MAX_WIDTH / 2) * 2;
    localparam int CAP_H = (MAX_HEIGHT / 4) * 4;

    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic       wr_en;
    logic [7:0] w_raw;
    logic [8:0] w_rnd;
    logic [8:0] w_fin;
    logic [6:0] h_raw;
    logic [8:0] h_rnd;
    logic [8:0] h_fin;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 7'd64;
        end
        else if (wr_en)
        begin
            if (paddr[2] == bcr_pkg::ADDR_WIDTH_REG)
            begin
                width_reg <= pwdata[7:0];
            end
            else
            begin
                height_reg <= pwdata[6:0];
            end
        end
    end

    assign prdata = (paddr[2] == bcr_pkg::ADDR_HEIGHT_REG) ? {25'd0, height_reg}
                                                           : {24'd0, width_reg};

    always_comb
    begin
        w_raw = (width_reg == 8'd0) ? 8'd1 : width_reg;
        w_rnd = ({1'b0, w_raw} + 9'd1) & ~9'd1;
        w_fin = (w_rnd > 9'(CAP_W)) ? 9'(CAP_W) : w_rnd;
        h_raw = (height_reg == 7'd0) ? 7'd1 : height_reg;
        h_rnd = ({2'b0, h_raw} + 9'd3) & ~9'd3;
        h_fin = (h_rnd > 9'(CAP_H)) ? 9'(CAP_H) : h_rnd;
        geom.w_used = w_fin;
        geom.h_used = h_fin[7:0];
        geom.cells  = w_fin[8:1];
        geom.bands  = h_fin[7:2];
    end

endmodule
